[rtl/srqs_pkg.sv]
// ----------------------------------------------------------------------------
// Sprite record quad setup package
// Shared widths, register indexes and prim/alpha codes for the quad setup.
// ----------------------------------------------------------------------------
package srqs_pkg;

	// Width of the intermediate quad coordinates in 1/16 sprite units.
	localparam int COORD_W = 24;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_ORIGIN_X = 3'd0,
		REG_ORIGIN_Y = 3'd1,
		REG_SCALE_X  = 3'd2,
		REG_SCALE_Y  = 3'd3,
		REG_TEXTURED = 3'd4
	} cfg_reg_t;

	localparam logic [15:0] ORIGIN_RESET   = 16'd32768;
	localparam logic [15:0] SCALE_RESET    = 16'd256;
	localparam logic        TEXTURED_RESET = 1'b1;

	localparam logic [6:0] PRIM_TEXTURED = 7'h1D;
	localparam logic [6:0] PRIM_FLAT     = 7'h0D;
	localparam logic [6:0] PRIM_BLEND    = 7'h40;
	localparam logic [7:0] ALPHA_OPAQUE  = 8'h80;

	localparam int FLIP_X_BIT = 4;
	localparam int FLIP_Y_BIT = 5;

	localparam int PIPE_LATENCY = 5;

endpackage

[rtl/sprite_record_quad_setup_top.sv]
// ----------------------------------------------------------------------------
// Sprite record quad setup
// Turns one sprite record into one screen-space quad with UVs, prim and alpha.
// ----------------------------------------------------------------------------
// Usage:
// A record is transferred on the rising edge where start is high and busy is
// low. The block is fully pipelined in five register stages (extent multiply,
// centering, corner sums, projection multiply, origin add), so one record can
// be transferred in every cycle. Its quad comes from the origin add output
// registers; done is high for exactly one cycle with all result fields valid.
// The receiver cannot stall; results are presented once and never held.
// Configuration (origin, scales, textured) is written through cfg_valid /
// cfg_ready with a register index and 16-bit data; unknown indexes are
// ignored. Write it only while no record is in flight.
// During reset and the first cycle after it busy is high and cfg_ready is
// low; the pipeline valid bits clear and the configuration takes its
// default values (origin 32768, scales 256, textured).
// Corner arithmetic wraps modulo 2^32 as two's complement.
// ----------------------------------------------------------------------------
module sprite_record_quad_setup_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [7:0]                          mode_flags,
	input  logic [7:0]                          tex_u,
	input  logic [7:0]                          tex_v,
	input  logic [7:0]                          width_plus_one,
	input  logic [7:0]                          height_plus_one,
	input  logic [7:0]                          alpha_doubled,
	input  logic signed [7:0]                   offset_x,
	input  logic signed [7:0]                   offset_y,
	input  logic [15:0]                         record_scale,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [srqs_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [srqs_pkg::CFG_DATA_W-1:0]     cfg_data,
	output logic                                done,
	output logic signed [31:0]                  corner_x0,
	output logic signed [31:0]                  corner_y0,
	output logic signed [31:0]                  corner_x1,
	output logic signed [31:0]                  corner_y1,
	output logic [7:0]                          uv_u0,
	output logic [7:0]                          uv_v0,
	output logic signed [9:0]                   uv_u1,
	output logic signed [9:0]                   uv_v1,
	output logic [6:0]                          prim_word,
	output logic [7:0]                          alpha_out
);

	localparam int CW = srqs_pkg::COORD_W;

	// Control and configuration registers.
	logic        busy_q;
	logic [15:0] origin_x_q;
	logic [15:0] origin_y_q;
	logic [15:0] scale_x_q;
	logic [15:0] scale_y_q;
	logic        textured_q;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic accept;

	assign accept    = start & ~busy_q;
	assign busy      = busy_q;
	assign cfg_ready = ~busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b1;
			origin_x_q <= srqs_pkg::ORIGIN_RESET;
			origin_y_q <= srqs_pkg::ORIGIN_RESET;
			scale_x_q  <= srqs_pkg::SCALE_RESET;
			scale_y_q  <= srqs_pkg::SCALE_RESET;
			textured_q <= srqs_pkg::TEXTURED_RESET;
		end else begin
			busy_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					srqs_pkg::REG_ORIGIN_X: origin_x_q <= cfg_data;
					srqs_pkg::REG_ORIGIN_Y: origin_y_q <= cfg_data;
					srqs_pkg::REG_SCALE_X:  scale_x_q  <= cfg_data;
					srqs_pkg::REG_SCALE_Y:  scale_y_q  <= cfg_data;
					srqs_pkg::REG_TEXTURED: textured_q <= cfg_data[0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	// ---------------- Stage 1: extent products, UV, prim, alpha ----------------
	logic signed [8:0]  w_c, h_c;
	logic signed [16:0] rscale_c;
	logic signed [25:0] prod_w_c, prod_h_c;
	logic signed [9:0]  uv_u1_c, uv_v1_c;
	logic               blend_c;
	logic [6:0]         prim_c;
	logic [7:0]         alpha_c;

	always_comb begin
		w_c      = $signed({1'b0, width_plus_one}) - 9'sd1;
		h_c      = $signed({1'b0, height_plus_one}) - 9'sd1;
		rscale_c = $signed({1'b0, record_scale});
		prod_w_c = w_c * rscale_c;
		prod_h_c = h_c * rscale_c;
		uv_u1_c  = $signed({2'b00, tex_u}) + 10'(w_c);
		uv_v1_c  = $signed({2'b00, tex_v}) + 10'(h_c);
		blend_c  = |mode_flags[1:0];
		prim_c   = (textured_q ? srqs_pkg::PRIM_TEXTURED : srqs_pkg::PRIM_FLAT)
			| (blend_c ? srqs_pkg::PRIM_BLEND : 7'd0);
		alpha_c  = blend_c ? {1'b0, alpha_doubled[7:1]} : srqs_pkg::ALPHA_OPAQUE;
	end

	logic signed [8:0]  w_s1, h_s1;
	logic signed [25:0] prod_w_s1, prod_h_s1;
	logic signed [7:0]  offx_s1, offy_s1;
	logic               flip_x_s1, flip_y_s1;

	typedef struct packed {
		logic [7:0]        u0;
		logic [7:0]        v0;
		logic signed [9:0] u1;
		logic signed [9:0] v1;
		logic [6:0]        prim;
		logic [7:0]        alpha;
	} side_t;

	side_t side_s1, side_s2, side_s3, side_s4;

	always_ff @(posedge clk) begin
		if (accept) begin
			w_s1       <= w_c;
			h_s1       <= h_c;
			prod_w_s1  <= prod_w_c;
			prod_h_s1  <= prod_h_c;
			offx_s1    <= offset_x;
			offy_s1    <= offset_y;
			flip_x_s1  <= mode_flags[srqs_pkg::FLIP_X_BIT];
			flip_y_s1  <= mode_flags[srqs_pkg::FLIP_Y_BIT];
			side_s1    <= '{u0: tex_u, v0: tex_v, u1: uv_u1_c, v1: uv_v1_c,
				prim: prim_c, alpha: alpha_c};
		end
	end

	// ---------------- Stage 2: quad extent and centering ----------------
	logic signed [25:0]   qw_full_c, qh_full_c;
	logic signed [CW-1:0] quad_w_c, quad_h_c;
	logic signed [CW-1:0] diff_w_c, diff_h_c;
	logic signed [CW-1:0] bias_w_c, bias_h_c;
	logic signed [CW-1:0] half_w_c, half_h_c;

	always_comb begin
		qw_full_c = prod_w_s1 >>> 4;
		qh_full_c = prod_h_s1 >>> 4;
		quad_w_c  = qw_full_c[CW-1:0];
		quad_h_c  = qh_full_c[CW-1:0];
		diff_w_c  = $signed({{(CW-13){w_s1[8]}}, w_s1, 4'b0000}) - quad_w_c;
		diff_h_c  = $signed({{(CW-13){h_s1[8]}}, h_s1, 4'b0000}) - quad_h_c;
		// Adding one to a negative value before the shift rounds toward zero.
		bias_w_c  = diff_w_c + $signed({{(CW-1){1'b0}}, diff_w_c[CW-1]});
		bias_h_c  = diff_h_c + $signed({{(CW-1){1'b0}}, diff_h_c[CW-1]});
		half_w_c  = bias_w_c >>> 1;
		half_h_c  = bias_h_c >>> 1;
	end

	logic signed [CW-1:0] quad_w_s2, quad_h_s2, half_w_s2, half_h_s2;
	logic signed [7:0]    offx_s2, offy_s2;
	logic                 flip_x_s2, flip_y_s2;

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			quad_w_s2 <= quad_w_c;
			quad_h_s2 <= quad_h_c;
			half_w_s2 <= half_w_c;
			half_h_s2 <= half_h_c;
			offx_s2   <= offx_s1;
			offy_s2   <= offy_s1;
			flip_x_s2 <= flip_x_s1;
			flip_y_s2 <= flip_y_s1;
			side_s2   <= side_s1;
		end
	end

	// ---------------- Stage 3: corners and flips ----------------
	logic signed [CW-1:0] lo_x_c, lo_y_c, hi_x_c, hi_y_c;

	always_comb begin
		lo_x_c = $signed({{(CW-12){offx_s2[7]}}, offx_s2, 4'b0000}) + half_w_s2;
		lo_y_c = $signed({{(CW-12){offy_s2[7]}}, offy_s2, 4'b0000}) + half_h_s2;
		hi_x_c = lo_x_c + quad_w_s2;
		hi_y_c = lo_y_c + quad_h_s2;
	end

	logic signed [CW-1:0] x0_s3, x1_s3, y0_s3, y1_s3;

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			x0_s3   <= flip_x_s2 ? hi_x_c : lo_x_c;
			x1_s3   <= flip_x_s2 ? lo_x_c : hi_x_c;
			y0_s3   <= flip_y_s2 ? hi_y_c : lo_y_c;
			y1_s3   <= flip_y_s2 ? lo_y_c : hi_y_c;
			side_s3 <= side_s2;
		end
	end

	// ---------------- Stage 4: projection scale ----------------
	logic signed [CW+16:0] px0_c, px1_c, py0_c, py1_c;

	always_comb begin
		px0_c = x0_s3 * $signed({1'b0, scale_x_q});
		px1_c = x1_s3 * $signed({1'b0, scale_x_q});
		py0_c = y0_s3 * $signed({1'b0, scale_y_q});
		py1_c = y1_s3 * $signed({1'b0, scale_y_q});
	end

	logic signed [31:0] px0_s4, px1_s4, py0_s4, py1_s4;

	always_ff @(posedge clk) begin
		if (valid_s3) begin
			px0_s4  <= px0_c[31:0];
			px1_s4  <= px1_c[31:0];
			py0_s4  <= py0_c[31:0];
			py1_s4  <= py1_c[31:0];
			side_s4 <= side_s3;
		end
	end

	// ---------------- Stage 5: origin add, output registers ----------------
	logic signed [31:0] gx0_c, gx1_c, gy0_c, gy1_c;

	always_comb begin
		gx0_c = $signed({16'd0, origin_x_q}) + (px0_s4 >>> 8);
		gx1_c = $signed({16'd0, origin_x_q}) + (px1_s4 >>> 8);
		gy0_c = $signed({16'd0, origin_y_q}) + (py0_s4 >>> 9);
		gy1_c = $signed({16'd0, origin_y_q}) + (py1_s4 >>> 9);
	end

	always_ff @(posedge clk) begin
		if (valid_s4) begin
			corner_x0 <= gx0_c;
			corner_x1 <= gx1_c;
			corner_y0 <= gy0_c;
			corner_y1 <= gy1_c;
			uv_u0     <= side_s4.u0;
			uv_v0     <= side_s4.v0;
			uv_u1     <= side_s4.u1;
			uv_v1     <= side_s4.v1;
			prim_word <= side_s4.prim;
			alpha_out <= side_s4.alpha;
		end
	end

	assign done = valid_s5;

endmodule

[rtl/srqs_checker.sv]
// ----------------------------------------------------------------------------
// Sprite record quad setup checker
// Port-level timing and result code checks, bound to the top level.
// ----------------------------------------------------------------------------
module srqs_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input logic [6:0] prim_word,
	input logic [7:0] alpha_out
);

	// Every transferred record yields exactly one result after a fixed latency.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##5 done)
		else $error("record transfer not followed by a result");

	a_no_spurious_result: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, srqs_pkg::PIPE_LATENCY))
		else $error("result without a matching record transfer");

	a_prim_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((prim_word & ~srqs_pkg::PRIM_BLEND) == srqs_pkg::PRIM_FLAT ||
			(prim_word & ~srqs_pkg::PRIM_BLEND) == srqs_pkg::PRIM_TEXTURED))
		else $error("prim word is not a legal code");

	// Opaque prims carry the fixed alpha; blended ones never exceed half range.
	a_alpha_matches_prim: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (prim_word[6] ? (alpha_out[7] == 1'b0)
			: (alpha_out == srqs_pkg::ALPHA_OPAQUE)))
		else $error("alpha does not match blend state of prim word");

endmodule

bind sprite_record_quad_setup_top srqs_checker u_srqs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.done      (done),
	.prim_word (prim_word),
	.alpha_out (alpha_out)
);

[tb/sprite_record_quad_setup_top_test.sv]
// ----------------------------------------------------------------------------
// Sprite record quad setup testbench
// Streams sprite records through the quad setup under several register
// settings, with random idle gaps. An in-bench predictor derives each
// quad from the record and the current settings. Each done strobe is
// checked field by field against the oldest predicted quad.
// ----------------------------------------------------------------------------
module sprite_record_quad_setup_top_test;

	localparam int MAX_GAP       = 12;
	localparam int STALL_LIMIT   = 2000;
	localparam int RANDOM_PHASES = 9;
	localparam int PHASE_RECORDS = 200;
	localparam int MAX_PRINTED   = 30;

	localparam logic [srqs_pkg::CFG_INDEX_W-1:0] REG_SPARE_FIRST =
		srqs_pkg::CFG_INDEX_W'(srqs_pkg::REG_TEXTURED + 1);
	localparam logic [srqs_pkg::CFG_INDEX_W-1:0] REG_SPARE_LAST  = '1;

	localparam logic [7:0] BLEND_OFF   = 8'h00;
	localparam logic [7:0] BLEND_MODE1 = 8'h01;
	localparam logic [7:0] BLEND_MODE2 = 8'h02;
	localparam logic [7:0] BLEND_MODE3 = 8'h03;
	localparam logic [7:0] FLAG_FLIP_X = 8'(1 << srqs_pkg::FLIP_X_BIT);
	localparam logic [7:0] FLAG_FLIP_Y = 8'(1 << srqs_pkg::FLIP_Y_BIT);
	localparam logic [7:0] UNUSED_BITS = 8'hCC;

	typedef struct {
		logic [7:0]        mode;
		logic [7:0]        u;
		logic [7:0]        v;
		logic [7:0]        wp1;
		logic [7:0]        hp1;
		logic [7:0]        a2;
		logic signed [7:0] ox;
		logic signed [7:0] oy;
		logic [15:0]       rs;
		int                gap;
	} record_t;

	typedef struct {
		logic signed [31:0] x0;
		logic signed [31:0] y0;
		logic signed [31:0] x1;
		logic signed [31:0] y1;
		logic [7:0]         u0;
		logic [7:0]         v0;
		logic signed [9:0]  u1;
		logic signed [9:0]  v1;
		logic [6:0]         prim;
		logic [7:0]         alpha;
	} quad_t;

	typedef struct {
		logic [srqs_pkg::CFG_INDEX_W-1:0] idx;
		logic [srqs_pkg::CFG_DATA_W-1:0]  data;
	} reg_write_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [7:0] mode_flags = '0, tex_u = '0, tex_v = '0;
	logic [7:0] width_plus_one = '0, height_plus_one = '0, alpha_doubled = '0;
	logic signed [7:0] offset_x = '0, offset_y = '0;
	logic [15:0] record_scale = '0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [srqs_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [srqs_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic done;
	logic signed [31:0] corner_x0, corner_y0, corner_x1, corner_y1;
	logic [7:0] uv_u0, uv_v0;
	logic signed [9:0] uv_u1, uv_v1;
	logic [6:0] prim_word;
	logic [7:0] alpha_out;

	// Register contents as the block should hold them.
	logic [15:0] cur_origin_x = srqs_pkg::ORIGIN_RESET, cur_origin_y = srqs_pkg::ORIGIN_RESET;
	logic [15:0] cur_scale_x = srqs_pkg::SCALE_RESET, cur_scale_y = srqs_pkg::SCALE_RESET;
	logic cur_textured = srqs_pkg::TEXTURED_RESET;

	record_t record_q[$];
	quad_t quad_q[$];
	reg_write_t reg_write_q[$];

	record_t on_bus, next_rec;
	reg_write_t pending_write;
	quad_t want;
	logic holding = 1'b0;
	logic load;
	int gap_left = 0;
	int gap_ceiling = MAX_GAP;
	int n_records = 0, n_quads = 0, n_reg_writes = 0, n_errors = 0, n_settings = 1;
	int idle_cycles = 0;

	sprite_record_quad_setup_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.mode_flags(mode_flags),
		.tex_u(tex_u),
		.tex_v(tex_v),
		.width_plus_one(width_plus_one),
		.height_plus_one(height_plus_one),
		.alpha_doubled(alpha_doubled),
		.offset_x(offset_x),
		.offset_y(offset_y),
		.record_scale(record_scale),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.done(done),
		.corner_x0(corner_x0),
		.corner_y0(corner_y0),
		.corner_x1(corner_x1),
		.corner_y1(corner_y1),
		.uv_u0(uv_u0),
		.uv_v0(uv_v0),
		.uv_u1(uv_u1),
		.uv_v1(uv_v1),
		.prim_word(prim_word),
		.alpha_out(alpha_out)
	);

	always #1 clk = ~clk;

	// Scales a corner, shifts it arithmetically and adds the origin, all mod 2^32.
	function automatic logic [31:0] project_coord(input int coord, input logic [15:0] scale,
			input int shift, input logic [15:0] origin);
		int prod;
		prod = coord * int'(scale);
		return (prod >>> shift) + int'(origin);
	endfunction

	function automatic quad_t quad_of_record(input record_t r);
		int w, h, qw, qh, x0, y0, x1, y1, t;
		logic blend;
		quad_t q;
		w = int'(r.wp1) - 1;
		h = int'(r.hp1) - 1;
		qw = (w * int'(r.rs)) >>> 4;
		qh = (h * int'(r.rs)) >>> 4;
		// Centering divides signed values, so it truncates toward zero.
		x0 = int'(r.ox) * 16 + (w * 16 - qw) / 2;
		y0 = int'(r.oy) * 16 + (h * 16 - qh) / 2;
		x1 = x0 + qw;
		y1 = y0 + qh;
		if (r.mode[srqs_pkg::FLIP_X_BIT]) begin
			t = x1;
			x1 = x0;
			x0 = t;
		end
		if (r.mode[srqs_pkg::FLIP_Y_BIT]) begin
			t = y1;
			y1 = y0;
			y0 = t;
		end
		q.x0 = project_coord(x0, cur_scale_x, 8, cur_origin_x);
		q.x1 = project_coord(x1, cur_scale_x, 8, cur_origin_x);
		q.y0 = project_coord(y0, cur_scale_y, 9, cur_origin_y);
		q.y1 = project_coord(y1, cur_scale_y, 9, cur_origin_y);
		q.u0 = r.u;
		q.v0 = r.v;
		q.u1 = 10'(int'(r.u) + w);
		q.v1 = 10'(int'(r.v) + h);
		blend = |r.mode[1:0];
		q.prim = (cur_textured ? srqs_pkg::PRIM_TEXTURED : srqs_pkg::PRIM_FLAT)
			| (blend ? srqs_pkg::PRIM_BLEND : 7'd0);
		q.alpha = blend ? (r.a2 >> 1) : srqs_pkg::ALPHA_OPAQUE;
		return q;
	endfunction

	function automatic logic [7:0] pick_byte(input logic [7:0] lo, input logic [7:0] hi);
		case ($urandom_range(0, 7))
			0: return lo;
			1: return hi;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] pick_word();
		case ($urandom_range(0, 7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return srqs_pkg::SCALE_RESET;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic add_record(input logic [7:0] mode, u, v, wp1, hp1, a2,
			input logic [7:0] ox, oy, input logic [15:0] rs);
		record_t r;
		r.mode = mode;
		r.u = u;
		r.v = v;
		r.wp1 = wp1;
		r.hp1 = hp1;
		r.a2 = a2;
		r.ox = ox;
		r.oy = oy;
		r.rs = rs;
		// At least a quarter of the records follow their predecessor with no gap at all.
		r.gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, gap_ceiling);
		record_q.push_back(r);
	endtask

	task automatic add_random_record();
		add_record(8'($urandom), pick_byte(8'h00, 8'hFF), pick_byte(8'h00, 8'hFF),
			pick_byte(8'h00, 8'hFF), pick_byte(8'h00, 8'hFF), pick_byte(8'h00, 8'hFF),
			pick_byte(8'h80, 8'h7F), pick_byte(8'h80, 8'h7F), pick_word());
	endtask

	task automatic queue_reg_write(input logic [srqs_pkg::CFG_INDEX_W-1:0] idx,
			input logic [srqs_pkg::CFG_DATA_W-1:0] data);
		reg_write_t wr;
		wr.idx = idx;
		wr.data = data;
		reg_write_q.push_back(wr);
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (record_q.size() != 0 || holding || start || quad_q.size() != 0 ||
			reg_write_q.size() != 0 || cfg_valid);
	endtask

	task automatic report_mismatch(input string msg);
		if (n_errors < MAX_PRINTED)
			$display("mismatch on quad %0d: %s", n_quads, msg);
		n_errors++;
	endtask

	task automatic check_field(input string name, input logic signed [31:0] got,
			input logic signed [31:0] exp_val);
		if (got !== exp_val)
			report_mismatch($sformatf("%s is %0d, predicted %0d", name, got, exp_val));
	endtask

	// Record driver: holds start until the transfer, then waits out the next gap.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			holding = 1'b0;
			gap_left = 0;
		end else begin
			if (start && !busy) begin
				quad_q.push_back(quad_of_record(on_bus));
				n_records++;
			end
			if (!start || !busy) begin
				load = 1'b0;
				if (!holding && record_q.size() > 0) begin
					next_rec = record_q.pop_front();
					gap_left = next_rec.gap;
					holding = 1'b1;
				end
				if (holding) begin
					if (gap_left == 0) begin
						on_bus = next_rec;
						holding = 1'b0;
						load = 1'b1;
						mode_flags <= next_rec.mode;
						tex_u <= next_rec.u;
						tex_v <= next_rec.v;
						width_plus_one <= next_rec.wp1;
						height_plus_one <= next_rec.hp1;
						alpha_doubled <= next_rec.a2;
						offset_x <= next_rec.ox;
						offset_y <= next_rec.oy;
						record_scale <= next_rec.rs;
					end else begin
						gap_left--;
					end
				end
				start <= load;
			end
		end
	end

	// Register write driver; the expected settings follow each transfer.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_valid <= 1'b0;
			cur_origin_x = srqs_pkg::ORIGIN_RESET;
			cur_origin_y = srqs_pkg::ORIGIN_RESET;
			cur_scale_x = srqs_pkg::SCALE_RESET;
			cur_scale_y = srqs_pkg::SCALE_RESET;
			cur_textured = srqs_pkg::TEXTURED_RESET;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					srqs_pkg::REG_ORIGIN_X: cur_origin_x = cfg_data;
					srqs_pkg::REG_ORIGIN_Y: cur_origin_y = cfg_data;
					srqs_pkg::REG_SCALE_X:  cur_scale_x = cfg_data;
					srqs_pkg::REG_SCALE_Y:  cur_scale_y = cfg_data;
					srqs_pkg::REG_TEXTURED: cur_textured = cfg_data[0];
					default: ;
				endcase
				n_reg_writes++;
			end
			if (!cfg_valid || cfg_ready) begin
				if (reg_write_q.size() > 0) begin
					pending_write = reg_write_q.pop_front();
					cfg_valid <= 1'b1;
					cfg_index <= pending_write.idx;
					cfg_data <= pending_write.data;
				end else begin
					cfg_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (quad_q.size() == 0) begin
				report_mismatch("quad with no record outstanding");
			end else begin
				want = quad_q.pop_front();
				check_field("corner_x0", corner_x0, want.x0);
				check_field("corner_y0", corner_y0, want.y0);
				check_field("corner_x1", corner_x1, want.x1);
				check_field("corner_y1", corner_y1, want.y1);
				check_field("uv_u0", {24'd0, uv_u0}, {24'd0, want.u0});
				check_field("uv_v0", {24'd0, uv_v0}, {24'd0, want.v0});
				check_field("uv_u1", uv_u1, want.u1);
				check_field("uv_v1", uv_v1, want.v1);
				check_field("prim_word", {25'd0, prim_word}, {25'd0, want.prim});
				check_field("alpha_out", {24'd0, alpha_out}, {24'd0, want.alpha});
			end
			n_quads++;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done || (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("no transfer for %0d cycles", idle_cycles);
				$display("FAIL sprite_record_quad_setup_top");
				$finish;
			end
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed records under the reset settings.
		add_record(BLEND_OFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000);
		add_record(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h7F, 16'hFFFF);
		add_record(BLEND_OFF, 8'h10, 8'h20, 8'h40, 8'h30, 8'h80, 8'h80, 8'h80, 16'h0100);
		add_record(FLAG_FLIP_X, 8'h05, 8'h06, 8'h21, 8'h11, 8'h40, 8'hF0, 8'h10, 16'h0180);
		add_record(FLAG_FLIP_Y, 8'h05, 8'h06, 8'h21, 8'h11, 8'h40, 8'hF0, 8'h10, 16'h0180);
		add_record(FLAG_FLIP_X | FLAG_FLIP_Y, 8'h05, 8'h06, 8'h21, 8'h11, 8'h40,
			8'hF0, 8'h10, 16'h0180);
		add_record(BLEND_MODE1, 8'h01, 8'h02, 8'h08, 8'h08, 8'hFF, 8'h00, 8'h00, 16'h0100);
		add_record(BLEND_MODE2, 8'h01, 8'h02, 8'h08, 8'h08, 8'h01, 8'h00, 8'h00, 16'h0100);
		add_record(BLEND_MODE3, 8'h01, 8'h02, 8'h08, 8'h08, 8'h80, 8'h00, 8'h00, 16'h0100);
		add_record(UNUSED_BITS, 8'h33, 8'h44, 8'h10, 8'h10, 8'h22, 8'h02, 8'hFE, 16'h0200);
		// Zero extent and an extent of minus one, with the UV end going below zero.
		add_record(BLEND_OFF, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h01, 8'hFF, 16'h0100);
		// Odd negative centering term, where truncation and floor differ.
		add_record(BLEND_OFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 16'h0001);
		add_record(BLEND_OFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h80, 8'h7F, 16'h0001);
		add_record(8'h55, 8'h55, 8'hAA, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 16'hAAAA);
		add_record(8'hAA, 8'hAA, 8'h55, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 16'h5555);
		add_record(FLAG_FLIP_X | FLAG_FLIP_Y | BLEND_MODE3, 8'hFF, 8'h00, 8'h00, 8'hFF,
			8'hFE, 8'h80, 8'h80, 16'hFFFF);
		wait_drained();

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			if (phase == 0) begin
				// Smallest origins, largest scales: corners wrap. Upper data bits are dropped.
				queue_reg_write(srqs_pkg::REG_ORIGIN_X, 16'h0000);
				queue_reg_write(srqs_pkg::REG_ORIGIN_Y, 16'h0000);
				queue_reg_write(srqs_pkg::REG_SCALE_X, 16'hFFFF);
				queue_reg_write(srqs_pkg::REG_SCALE_Y, 16'hFFFF);
				queue_reg_write(srqs_pkg::REG_TEXTURED, 16'hFFFE);
				queue_reg_write(REG_SPARE_FIRST, 16'hFFFF);
			end else if (phase == 1) begin
				queue_reg_write(srqs_pkg::REG_ORIGIN_X, 16'hFFFF);
				queue_reg_write(srqs_pkg::REG_ORIGIN_Y, 16'hFFFF);
				queue_reg_write(srqs_pkg::REG_SCALE_X, 16'h0000);
				queue_reg_write(srqs_pkg::REG_SCALE_Y, 16'h0000);
				queue_reg_write(srqs_pkg::REG_TEXTURED, 16'h0001);
				queue_reg_write(REG_SPARE_LAST, 16'h0000);
			end else begin
				queue_reg_write(srqs_pkg::REG_ORIGIN_X, pick_word());
				queue_reg_write(srqs_pkg::REG_ORIGIN_Y, pick_word());
				queue_reg_write(srqs_pkg::REG_SCALE_X, pick_word());
				queue_reg_write(srqs_pkg::REG_SCALE_Y, pick_word());
				queue_reg_write(srqs_pkg::REG_TEXTURED, 16'($urandom));
				queue_reg_write(srqs_pkg::CFG_INDEX_W'($urandom_range(REG_SPARE_FIRST,
					REG_SPARE_LAST)), 16'($urandom));
			end
			wait_drained();
			n_settings++;
			// Every third phase streams back to back with no idle cycles.
			gap_ceiling = (phase % 3 == 0) ? 0 : MAX_GAP;
			for (int i = 0; i < PHASE_RECORDS; i++)
				add_random_record();
			wait_drained();
		end

		repeat (4 * srqs_pkg::PIPE_LATENCY) @(posedge clk);
		@(negedge clk);
		$display("%0d records sent, %0d quads checked, %0d register writes, %0d settings",
			n_records, n_quads, n_reg_writes, n_settings);
		$display("%0d mismatches, %0d quads still outstanding", n_errors, quad_q.size());
		if (n_errors == 0 && quad_q.size() == 0)
			$display("PASS sprite_record_quad_setup_top");
		else
			$display("FAIL sprite_record_quad_setup_top");
		$finish;
	end

endmodule

[sim.f]
rtl/srqs_pkg.sv
rtl/sprite_record_quad_setup_top.sv
rtl/srqs_checker.sv
tb/sprite_record_quad_setup_top_test.sv
